FILE: hw/rtl/dvca_pkg.sv
package dvca_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int VOICE_W     = 6;
   localparam int GAIN_W      = 29;
   localparam int CSR_W       = 16;
   localparam int CSR_INDEX_W = 3;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic [VOICE_W-1:0]         voice_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic [CSR_INDEX_W-1:0]     csr_index_type;

   // register indexes
   localparam csr_index_type CSR_BASE_GAIN = 3'd0;
   localparam csr_index_type CSR_CV2_GAIN  = 3'd1;
   localparam csr_index_type CSR_IN1_LEVEL = 3'd2;
   localparam csr_index_type CSR_IN2_LEVEL = 3'd3;
   localparam csr_index_type CSR_OUT_LEVEL = 3'd4;
   localparam csr_index_type CSR_EXP_MODE  = 3'd5;

   localparam logic [15:0] LEVEL_RESET = 16'd16384;

   // exponential gain table, Q30 arithmetic, entries in Q5.24
   localparam longint          SLOPE_Q30 = 64'sd14267045263;
   localparam longint unsigned LN2_Q30   = 64'd744261118;
   localparam longint unsigned ONE_Q30   = 64'd1073741824;
   localparam gain_type        GAIN_MAX  = 29'd268435456;

endpackage

FILE: hw/rtl/dvca_req_if.sv
interface dvca_req_if;
   logic                  valid;
   logic                  ready;
   dvca_pkg::voice_type   voice;
   dvca_pkg::sample_type  gain_cv1;
   dvca_pkg::sample_type  gain_cv2;
   dvca_pkg::sample_type  audio_in1;
   dvca_pkg::sample_type  audio_in2;

   modport source (output valid, voice, gain_cv1, gain_cv2, audio_in1, audio_in2,
                   input ready);
   modport sink   (input valid, voice, gain_cv1, gain_cv2, audio_in1, audio_in2,
                   output ready);
endinterface

FILE: hw/rtl/dvca_rsp_if.sv
interface dvca_rsp_if;
   logic                  valid;
   logic                  ready;
   dvca_pkg::voice_type   voice_out;
   dvca_pkg::sample_type  audio_out;
   logic                  clipped;

   modport source (output valid, voice_out, audio_out, clipped, input ready);
   modport sink   (input valid, voice_out, audio_out, clipped, output ready);
endinterface

FILE: hw/rtl/dvca_ram.sv
module dvca_ram #(
   parameter int WIDTH = 29,
   parameter int DEPTH = 1025
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_a_ff <= mem_ff[raddr_a];
         rd_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

FILE: hw/rtl/dual_input_vca_lin_exp_core.sv
// Channel    Dir   Payload                                          Handshake
// req_chan   in    voice, gain_cv1, gain_cv2, audio_in1, audio_in2  valid/ready
// rsp_chan   out   voice_out, audio_out, clipped                    valid/ready
// csr_*      in    csr_index, csr_wdata                             csr_we, no wait
//
// One request per cycle while rsp_chan is not stalled; each reaches a valid
// response through the seven register stages, the first loaded at acceptance
// (multipliers, table read, gain multiply).
// After reset the gain table RAM is loaded, all EXP_TABLE_ENTRIES + 1 entries, with
// req_chan.ready low; register writes are taken during the load.
// A stalled response holds its stage; earlier stages keep filling empty slots.
module dual_input_vca_lin_exp_core #(
   parameter int EXP_TABLE_ENTRIES = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   dvca_req_if.sink                 req_chan,
   dvca_rsp_if.source               rsp_chan,
   input  logic                     csr_we,
   input  dvca_pkg::csr_index_type  csr_index,
   input  logic [dvca_pkg::CSR_W-1:0] csr_wdata
);

   localparam int DEPTH  = EXP_TABLE_ENTRIES + 1;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int POS_W  = 15 + ADDR_W;
   localparam int GW     = dvca_pkg::GAIN_W;

   // table entry k, evaluated at elaboration
   function automatic dvca_pkg::gain_type rom_value(input longint k);
      longint          y;
      longint unsigned yy;
      longint unsigned f;
      longint unsigned r;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned g;
      int              n;
      int              s;
      y = ((2 * k - EXP_TABLE_ENTRIES) * dvca_pkg::SLOPE_Q30) / EXP_TABLE_ENTRIES;
      yy = unsigned'(y) + 64'd14 * dvca_pkg::ONE_Q30;
      n = int'(yy >> 30) - 14;
      f = yy & (dvca_pkg::ONE_Q30 - 64'd1);
      r = (f * dvca_pkg::LN2_Q30) >> 30;
      sum = dvca_pkg::ONE_Q30;
      term = dvca_pkg::ONE_Q30;
      term = ((term * r) >> 30) / 64'd1;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd2;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd3;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd4;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd5;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd6;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd7;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd8;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd9;  sum = sum + term;
      term = ((term * r) >> 30) / 64'd10; sum = sum + term;
      term = ((term * r) >> 30) / 64'd11; sum = sum + term;
      term = ((term * r) >> 30) / 64'd12; sum = sum + term;
      if (n >= 6) begin
         g = sum << (n - 6);
      end else begin
         s = 6 - n;
         g = (sum + (64'd1 << (s - 1))) >> s;
      end
      if (g > 64'(dvca_pkg::GAIN_MAX)) begin
         g = 64'(dvca_pkg::GAIN_MAX);
      end
      return g[GW-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [14:0] base_gain_ff;
   logic [14:0] cv2_gain_ff;
   logic [15:0] in1_level_ff;
   logic [15:0] in2_level_ff;
   logic [15:0] out_level_ff;
   logic        exp_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_gain_ff <= '0;
         cv2_gain_ff  <= '0;
         in1_level_ff <= dvca_pkg::LEVEL_RESET;
         in2_level_ff <= dvca_pkg::LEVEL_RESET;
         out_level_ff <= dvca_pkg::LEVEL_RESET;
         exp_mode_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            dvca_pkg::CSR_BASE_GAIN: base_gain_ff <= csr_wdata[14:0];
            dvca_pkg::CSR_CV2_GAIN:  cv2_gain_ff  <= csr_wdata[14:0];
            dvca_pkg::CSR_IN1_LEVEL: in1_level_ff <= csr_wdata;
            dvca_pkg::CSR_IN2_LEVEL: in2_level_ff <= csr_wdata;
            dvca_pkg::CSR_OUT_LEVEL: out_level_ff <= csr_wdata;
            dvca_pkg::CSR_EXP_MODE:  exp_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- gain table load ----------------
   dvca_pkg::gain_type rom_tab [DEPTH];
   for (genvar k = 0; k < DEPTH; k++) begin : g_rom
      assign rom_tab[k] = rom_value(longint'(k));
   end

   logic              fill_busy_ff;
   logic [ADDR_W-1:0] fill_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_busy_ff <= 1'b1;
         fill_cnt_ff  <= '0;
      end else if (fill_busy_ff) begin
         if (fill_cnt_ff == ADDR_W'(EXP_TABLE_ENTRIES)) begin
            fill_busy_ff <= 1'b0;
         end else begin
            fill_cnt_ff <= fill_cnt_ff + ADDR_W'(1);
         end
      end
   end

   // ---------------- pipeline control ----------------
   logic [7:1] vld_ff;
   logic [7:1] stage_en;
   logic       accept;

   always_comb begin
      stage_en[7] = !vld_ff[7] || rsp_chan.ready;
      for (int k = 6; k >= 1; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_chan.ready = stage_en[1] && !fill_busy_ff;
   assign accept         = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[1]) begin
            vld_ff[1] <= accept;
         end
         for (int k = 2; k <= 7; k++) begin
            if (stage_en[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   dvca_pkg::voice_type voice_ff [1:7];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         voice_ff[1] <= req_chan.voice;
      end
      for (int k = 2; k <= 7; k++) begin
         if (stage_en[k]) begin
            voice_ff[k] <= voice_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: products ----------------
   logic signed [31:0] s1_p_in;
   logic signed [32:0] s1_m1_full;
   logic signed [32:0] s1_m2_full;
   logic signed [31:0] s1_p_ff;
   logic signed [31:0] s1_m1_ff;
   logic signed [31:0] s1_m2_ff;
   dvca_pkg::sample_type s1_cv1_ff;

   assign s1_p_in    = $signed({1'b0, cv2_gain_ff}) * req_chan.gain_cv2;
   assign s1_m1_full = $signed({1'b0, in1_level_ff}) * req_chan.audio_in1;
   assign s1_m2_full = $signed({1'b0, in2_level_ff}) * req_chan.audio_in2;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         s1_p_ff   <= s1_p_in;
         s1_m1_ff  <= s1_m1_full[31:0];
         s1_m2_ff  <= s1_m2_full[31:0];
         s1_cv1_ff <= req_chan.gain_cv1;
      end
   end

   // ---------------- stage 2: control value, mix ----------------
   logic signed [31:0] p_rnd;
   logic signed [17:0] p_q14;
   logic signed [18:0] s2_v_in;
   logic signed [32:0] s2_mix_in;
   logic signed [18:0] s2_v_ff;
   logic signed [32:0] s2_mix_ff;

   // round half away from zero: add half, less one for negatives, then floor
   assign p_rnd = s1_p_ff + 32'sd8192 - $signed({31'd0, s1_p_ff[31]});
   assign p_q14 = p_rnd[31:14];
   assign s2_v_in = $signed({{3{s1_cv1_ff[15]}}, s1_cv1_ff})
                  + $signed({p_q14[17], p_q14})
                  + $signed({4'd0, base_gain_ff});
   assign s2_mix_in = $signed({s1_m1_ff[31], s1_m1_ff}) + $signed({s1_m2_ff[31], s1_m2_ff});

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         s2_v_ff   <= s2_v_in;
         s2_mix_ff <= s2_mix_in;
      end
   end

   // table address from the stage 2 control value; RAM output lines up with stage 3
   logic [POS_W-1:0]  tab_pos;
   logic [ADDR_W-1:0] tab_idx;
   logic [ADDR_W-1:0] tab_idx_hi;
   dvca_pkg::gain_type tab_lo;
   dvca_pkg::gain_type tab_hi;

   assign tab_pos    = POS_W'(s2_v_ff[14:0]) * POS_W'(EXP_TABLE_ENTRIES);
   assign tab_idx    = tab_pos[POS_W-1:15];
   assign tab_idx_hi = tab_idx + ADDR_W'(1);

   dvca_ram #(
      .WIDTH (GW),
      .DEPTH (DEPTH)
   ) u_exp_ram (
      .clock   (clock),
      .we      (fill_busy_ff),
      .waddr   (fill_cnt_ff),
      .wdata   (rom_tab[fill_cnt_ff]),
      .re      (stage_en[3]),
      .raddr_a (tab_idx),
      .raddr_b (tab_idx_hi),
      .rdata_a (tab_lo),
      .rdata_b (tab_hi)
   );

   // ---------------- stage 3: level multiply, range flags ----------------
   logic signed [49:0] s3_mo_raw_in;
   logic signed [49:0] s3_mo_raw_ff;
   logic signed [18:0] s3_v_ff;
   logic [14:0]        s3_frac_ff;
   logic               s3_le_zero_ff;
   logic               s3_ge_max_ff;

   assign s3_mo_raw_in = s2_mix_ff * $signed({1'b0, out_level_ff});

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         s3_mo_raw_ff  <= s3_mo_raw_in;
         s3_v_ff       <= s2_v_ff;
         s3_frac_ff    <= tab_pos[14:0];
         s3_le_zero_ff <= (s2_v_ff <= 19'sd0);
         s3_ge_max_ff  <= (s2_v_ff >= 19'sd32768);
      end
   end

   // ---------------- stage 4: interpolation, level rounding ----------------
   dvca_pkg::gain_type tab_diff;
   logic [GW+14:0]     frac_prod;
   dvca_pkg::gain_type s4_interp_in;
   logic signed [49:0] mo_rnd;
   dvca_pkg::gain_type s4_interp_ff;
   logic signed [31:0] s4_mo_ff;
   logic signed [18:0] s4_v_ff;
   logic               s4_le_zero_ff;
   logic               s4_ge_max_ff;

   // the table never decreases, so the step is non-negative
   assign tab_diff     = tab_hi - tab_lo;
   assign frac_prod    = (GW+15)'(tab_diff) * (GW+15)'(s3_frac_ff);
   assign s4_interp_in = tab_lo + frac_prod[GW+14:15];
   assign mo_rnd       = s3_mo_raw_ff + 50'sd131072 - $signed({49'd0, s3_mo_raw_ff[49]});

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         s4_interp_ff  <= s4_interp_in;
         s4_mo_ff      <= mo_rnd[49:18];
         s4_v_ff       <= s3_v_ff;
         s4_le_zero_ff <= s3_le_zero_ff;
         s4_ge_max_ff  <= s3_ge_max_ff;
      end
   end

   // ---------------- stage 5: gain law ----------------
   logic signed [29:0] s5_gain_in;
   logic               s5_clip_in;
   logic signed [29:0] s5_gain_ff;
   logic               s5_clip_ff;
   logic signed [31:0] s5_mo_ff;

   always_comb begin
      s5_clip_in = 1'b0;
      if (exp_mode_ff) begin
         if (s4_le_zero_ff) begin
            s5_gain_in = '0;
         end else if (s4_ge_max_ff || (s4_interp_ff >= dvca_pkg::GAIN_MAX)) begin
            s5_gain_in = $signed({1'b0, dvca_pkg::GAIN_MAX});
            s5_clip_in = 1'b1;
         end else begin
            s5_gain_in = $signed({1'b0, s4_interp_ff});
         end
      end else begin
         s5_gain_in = $signed({s4_v_ff[18], s4_v_ff, 10'd0});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         s5_gain_ff <= s5_gain_in;
         s5_clip_ff <= s5_clip_in;
         s5_mo_ff   <= s4_mo_ff;
      end
   end

   // ---------------- stage 6: gain multiply ----------------
   logic signed [61:0] s6_prod_in;
   logic signed [61:0] s6_prod_ff;
   logic               s6_clip_ff;

   assign s6_prod_in = s5_mo_ff * s5_gain_ff;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         s6_prod_ff <= s6_prod_in;
         s6_clip_ff <= s5_clip_ff;
      end
   end

   // ---------------- stage 7: round, saturate, response register ----------------
   logic signed [61:0] y_rnd;
   logic signed [27:0] y_full;
   dvca_pkg::sample_type s7_audio_in;
   logic               s7_sat;
   dvca_pkg::sample_type s7_audio_ff;
   logic               s7_clip_ff;

   assign y_rnd  = s6_prod_ff + 62'sd8589934592 - $signed({61'd0, s6_prod_ff[61]});
   assign y_full = y_rnd[61:34];

   always_comb begin
      s7_sat      = 1'b0;
      s7_audio_in = y_full[15:0];
      if (y_full > 28'sd32767) begin
         s7_audio_in = 16'sh7FFF;
         s7_sat      = 1'b1;
      end else if (y_full < -28'sd32768) begin
         s7_audio_in = 16'sh8000;
         s7_sat      = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         s7_audio_ff <= s7_audio_in;
         s7_clip_ff  <= s6_clip_ff || s7_sat;
      end
   end

   assign rsp_chan.valid     = vld_ff[7];
   assign rsp_chan.voice_out = voice_ff[7];
   assign rsp_chan.audio_out = s7_audio_ff;
   assign rsp_chan.clipped   = s7_clip_ff;

endmodule
